// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants and types for the prime tuple sieve.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int SIEVE_BITS  = 1048576;
  localparam int MAX_OFFSETS = 14;
  localparam int STORE_WORDS = (SIEVE_BITS + 63) / 64;
  localparam int WADDR_W     = $clog2(STORE_WORDS);
  localparam int POS_W       = $clog2(SIEVE_BITS) + 1;
  localparam int LAST_BITS   = SIEVE_BITS - (STORE_WORDS - 1) * 64;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_MARK   = 2'd1;
  localparam logic [1:0] OP_SCAN   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic REG_OFFSETS = 1'b0;
  localparam logic REG_MAXCAND = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] prime;
    logic [31:0] inverse;
    logic [31:0] start_residue;
    logic [13:0] word_index;
  } cmd_t;

  typedef struct packed {
    logic [19:0] candidate_index;
    logic        last_in_word;
  } res_t;

  function automatic logic [5:0] tuple_offset(input logic [3:0] k);
    logic [5:0] v;
    case (k)
      4'd0:  v = 6'd0;
      4'd1:  v = 6'd2;
      4'd2:  v = 6'd6;
      4'd3:  v = 6'd8;
      4'd4:  v = 6'd12;
      4'd5:  v = 6'd18;
      4'd6:  v = 6'd20;
      4'd7:  v = 6'd26;
      4'd8:  v = 6'd30;
      4'd9:  v = 6'd32;
      4'd10: v = 6'd36;
      4'd11: v = 6'd42;
      4'd12: v = 6'd48;
      4'd13: v = 6'd50;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/pts_front.sv =====
// ----------------------------------------------------------------------------
// pts_front
// Accepts commands, drops unused opcodes, queues them for the engine.
// ----------------------------------------------------------------------------
module pts_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  pts_pkg::cmd_t cmd_in,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output pts_pkg::cmd_t cmd_out
);

  pts_pkg::cmd_t q [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_push;
  logic       do_pop;
  logic       keep;

  assign full      = (count == 3'd4);
  assign keep      = (cmd_in.opcode != pts_pkg::OP_UNUSED);
  assign do_push   = push && !full && keep;
  assign cmd_valid = (count != 3'd0);
  assign do_pop    = cmd_take && cmd_valid;
  assign cmd_out   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, do_push} - {2'b0, do_pop};
    end
  end

endmodule

// ===== rtl/pts_back.sv =====
// ----------------------------------------------------------------------------
// pts_back
// Sieve engine: clear sweep, mark by read-modify-write, word scan.
// ----------------------------------------------------------------------------
module pts_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  pts_pkg::cmd_t cmd,
  input  logic [3:0]    offsets_in_use,
  input  logic [20:0]   max_candidates,
  output logic          res_valid,
  input  logic          res_take,
  output pts_pkg::res_t res
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_RSUM, S_RRED, S_MUL, S_MOD, S_MODW,
    S_MREAD, S_MWAIT, S_MWRITE, S_SREAD, S_SWAIT, S_SEMIT
  } state_t;

  localparam int WA = pts_pkg::WADDR_W;
  localparam int PW = pts_pkg::POS_W;

  state_t state;
  logic [63:0] mem [pts_pkg::STORE_WORDS];
  logic [63:0] rdata;
  logic        mem_we;
  logic [WA-1:0] mem_addr;
  logic [63:0] mem_wdata;

  logic [WA-1:0] sweep;
  logic [31:0] p;
  logic [31:0] inv;
  logic [31:0] rem;
  logic [3:0]  k;
  logic [3:0]  nlim;
  logic [32:0] r;
  logic [63:0] prod;
  logic [63:0] dividend;
  logic [32:0] partial;
  logic [6:0]  mbit;
  logic [PW+32:0] pos;
  logic [13:0] widx;
  logic [6:0]  b;
  logic [63:0] word;
  logic [20:0] ccount;
  logic        rmod_mode;
  logic        pv;
  pts_pkg::res_t pr;

  logic [32:0] trial;
  logic [32:0] shifted;
  logic [PW+32:0] pos_next;
  logic [5:0] b6;
  logic [6:0] limit_bits;
  logic       emit;

  function automatic logic [5:0] pts_package_off(input logic [3:0] kk);
    return pts_pkg::tuple_offset(kk);
  endfunction

  // last if no further clear bit below limit, or the count limit is hit now
  function automatic logic lastflag(input logic [63:0] w, input logic [6:0] bb,
                                    input logic [6:0] lim, input logic [20:0] left);
    logic [63:0] m;
    m = ~w & ~((64'd2 << bb[5:0]) - 64'd1);
    if (lim != 7'd64) m = m & ((64'd1 << lim[5:0]) - 64'd1);
    return (m == 64'd0) || (left == 21'd1) || (bb == 7'd63);
  endfunction

  assign b6 = b[5:0];
  assign limit_bits = (widx == 14'(pts_pkg::STORE_WORDS - 1)) ?
                      7'(pts_pkg::LAST_BITS) : 7'd64;
  assign shifted  = {partial[31:0], dividend[63]};
  assign trial    = shifted - {1'b0, p};
  assign pos_next = pos + (PW+33)'(p);
  assign emit     = (state == S_SEMIT) && (b < limit_bits) &&
                    (ccount < max_candidates) && !word[b6] && (!pv || res_take);

  assign cmd_take  = (state == S_IDLE) && cmd_valid;
  assign res_valid = pv;
  assign res       = pr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata <= mem[mem_addr];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = pos[WA+5:6];
    mem_wdata = rdata | (64'd1 << pos[5:0]);
    case (state)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1; mem_addr = sweep; mem_wdata = '0;
      end
      S_MWRITE: mem_we = 1'b1;
      S_SREAD, S_SWAIT, S_SEMIT: mem_addr = widx[WA-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      sweep  <= '0;
      ccount <= '0;
      pv     <= 1'b0;
    end else begin
      if (emit) pv <= 1'b1;
      else if (res_take) pv <= 1'b0;
      case (state)
        S_INIT, S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == WA'(pts_pkg::STORE_WORDS - 1)) begin
            sweep <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            p <= cmd.prime; inv <= cmd.inverse; rem <= cmd.start_residue;
            widx <= cmd.word_index;
            k <= '0;
            nlim <= (offsets_in_use > 4'(pts_pkg::MAX_OFFSETS)) ?
                    4'(pts_pkg::MAX_OFFSETS) : offsets_in_use;
            case (cmd.opcode)
              pts_pkg::OP_CLEAR: begin
                ccount <= '0; state <= S_CLEAR;
              end
              pts_pkg::OP_MARK:
                state <= (cmd.prime == 32'd0) ? S_IDLE : S_RSUM;
              pts_pkg::OP_SCAN: begin
                b <= '0;
                state <= (15'(cmd.word_index) >= 15'(pts_pkg::STORE_WORDS)) ?
                         S_IDLE : S_SREAD;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RSUM: begin
          if (k >= nlim) state <= S_IDLE;
          else begin
            r <= {1'b0, rem} + 33'(pts_package_off(k));
            state <= S_RRED;
          end
        end
        S_RRED: begin
          if ({1'b0, p} < r) begin
            if ({1'b0, p} < r - {1'b0, p}) begin
              dividend <= {31'd0, r - {1'b0, p}} << 31;
              partial <= '0; mbit <= 7'd33; rmod_mode <= 1'b1; state <= S_MODW;
            end else begin
              r <= r - {1'b0, p}; state <= S_MUL;
            end
          end else state <= S_MUL;
        end
        S_MUL: begin
          prod <= ({32'd0, p} - {31'd0, r}) * {32'd0, inv};
          state <= S_MOD;
        end
        S_MOD: begin
          dividend <= prod; partial <= '0; mbit <= 7'd64; rmod_mode <= 1'b0;
          state <= S_MODW;
        end
        S_MODW: begin
          dividend <= dividend << 1;
          partial <= (trial[32] == 1'b0) ? trial : shifted;
          mbit <= mbit - 7'd1;
          if (mbit == 7'd1) begin
            if (rmod_mode) begin
              r <= (trial[32] == 1'b0) ? trial : shifted;
              state <= S_MUL;
            end else begin
              pos <= (PW+33)'((trial[32] == 1'b0) ? trial : shifted);
              state <= S_MREAD;
            end
          end
        end
        S_MREAD: begin
          if (pos >= (PW+33)'(pts_pkg::SIEVE_BITS)) begin
            k <= k + 4'd1; state <= S_RSUM;
          end else state <= S_MWAIT;
        end
        S_MWAIT: state <= S_MWRITE;
        S_MWRITE: begin
          pos <= pos_next; state <= S_MREAD;
        end
        S_SREAD: state <= S_SWAIT;
        S_SWAIT: begin
          word <= rdata; state <= S_SEMIT;
        end
        S_SEMIT: begin
          if (b >= limit_bits || ccount >= max_candidates) state <= S_IDLE;
          else if (word[b6]) b <= b + 7'd1;
          else if (!pv || res_take) begin
            pr.candidate_index <= 20'({widx, b6});
            pr.last_in_word <= lastflag(word, b, limit_bits,
                                        max_candidates - ccount);
            ccount <= ccount + 21'd1;
            b <= b + 7'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/prime_tuple_sieve_top.sv =====
// ----------------------------------------------------------------------------
// prime_tuple_sieve_top
// Bit-packed prime tuple sieve with command queue and sieve engine.
// ----------------------------------------------------------------------------
// channel   direction  handshake
// command   in         push / full
// result    out        pop / empty
// config    in         cfg_we, cfg_index, cfg_data
// clear: sweeps all 16384 store words; the same sweep runs after reset.
// mark: per offset, a reduction, a multiply and a bit-serial modulo, then a read-modify-write per bit set.
// scan: reads the word, then walks its bits, holding while a result waits.
// stalls on the result side hold the scan; four commands may queue meanwhile.
// ----------------------------------------------------------------------------
module prime_tuple_sieve_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [31:0] prime,
  input  logic [31:0] inverse,
  input  logic [31:0] start_residue,
  input  logic [13:0] word_index,
  output logic        empty,
  input  logic        pop,
  output logic [19:0] candidate_index,
  output logic        last_in_word,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [20:0] cfg_data
);

  pts_pkg::cmd_t cmd_in;
  pts_pkg::cmd_t cmd_q;
  pts_pkg::res_t res;
  logic cmd_valid;
  logic cmd_take;
  logic res_valid;
  logic [3:0]  offsets_in_use;
  logic [20:0] max_candidates;

  assign cmd_in = '{opcode, prime, inverse, start_residue, word_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      offsets_in_use <= 4'd8;
      max_candidates <= 21'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        pts_pkg::REG_OFFSETS: offsets_in_use <= cfg_data[3:0];
        pts_pkg::REG_MAXCAND: max_candidates <= cfg_data;
        default: ;
      endcase
    end
  end

  pts_front u_front (
    .clk, .rst, .push, .full, .cmd_in,
    .cmd_valid, .cmd_take, .cmd_out(cmd_q)
  );

  pts_back u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd(cmd_q),
    .offsets_in_use, .max_candidates,
    .res_valid, .res_take(pop), .res
  );

  assign empty           = !res_valid;
  assign candidate_index = res.candidate_index;
  assign last_in_word    = res.last_in_word;

endmodule

// ===== verif/prime_tuple_sieve_top_test.sv =====
// ----------------------------------------------------------------------------
// prime_tuple_sieve_top_test
// Self-checking bench for the prime tuple sieve: a directed pass over the
// corner cases (unused opcode, zero and unit primes, oversized remainders,
// offset and candidate limits), then random command streams under three
// idling mixes. A scoreboard keeps its own copy of the sieve bits and the
// candidate count and checks every candidate transfer in order.
// ----------------------------------------------------------------------------
module prime_tuple_sieve_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CYCLE_LIMIT = 30000000;

  class sieve_scoreboard;
    logic [63:0] bits [pts_pkg::STORE_WORDS];
    int unsigned found;
    int unsigned offsets;
    int unsigned max_found;
    pts_pkg::res_t pending [$];
    int fails;
    longint last_hit;
    int unsigned offs_tab [14] = '{0, 2, 6, 8, 12, 18, 20, 26, 30, 32, 36, 42, 48, 50};

    function new();
      foreach (bits[i]) bits[i] = '0;
      found = 0;
      offsets = 8;
      max_found = 4096;
      fails = 0;
      last_hit = -1;
    endfunction

    // returns the number of bits set by a mark, -2 minus the candidates queued by a scan, -1 otherwise
    function longint note_command(logic [1:0] op, logic [31:0] p, logic [31:0] inv,
                                  logic [31:0] rem, logic [13:0] w);
      longint unsigned pp, r, hit, n;
      longint set_cnt;
      pts_pkg::res_t item;
      set_cnt = 0;
      if (op == pts_pkg::OP_CLEAR) begin
        foreach (bits[i]) bits[i] = '0;
        found = 0;
        return -1;
      end
      if (op == pts_pkg::OP_MARK) begin
        pp = p;
        if (pp == 0) return 0;
        n = (offsets > pts_pkg::MAX_OFFSETS) ? pts_pkg::MAX_OFFSETS : offsets;
        for (int k = 0; k < n; k++) begin
          r = longint'(rem) + offs_tab[k];
          if (pp < r) r = r - pp;
          if (pp < r) r = r % pp;
          hit = ((pp - r) * longint'(inv)) % pp;
          if (k == 0 && hit < pts_pkg::SIEVE_BITS) last_hit = hit;
          while (hit < pts_pkg::SIEVE_BITS) begin
            bits[hit >> 6][hit[5:0]] = 1'b1;
            hit = hit + pp;
            set_cnt++;
          end
        end
        return set_cnt;
      end
      if (op == pts_pkg::OP_SCAN) begin
        for (int b = 0; b < 64; b++) begin
          if (found >= max_found) break;
          if (bits[w][b]) continue;
          item.candidate_index = {w, b[5:0]};
          item.last_in_word = 1'b0;
          pending.insert(pending.size(), item);
          found++;
          set_cnt++;
        end
        if (set_cnt > 0) pending[pending.size() - 1].last_in_word = 1'b1;
        return -2 - set_cnt;
      end
      return -1;
    endfunction

    function void check_result(logic [19:0] idx, logic last);
      pts_pkg::res_t want;
      if (pending.size() == 0) begin
        $error("unexpected candidate transfer: candidate_index %0d", idx);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (idx !== want.candidate_index) begin
        $error("candidate_index: expected %0d, actual %0d", want.candidate_index, idx);
        fails++;
      end
      if (last !== want.last_in_word) begin
        $error("last_in_word: expected %0d, actual %0d", want.last_in_word, last);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  opcode = pts_pkg::OP_CLEAR;
  logic [31:0] prime = '0;
  logic [31:0] inverse = '0;
  logic [31:0] start_residue = '0;
  logic [13:0] word_index = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [19:0] candidate_index;
  logic        last_in_word;
  logic        cfg_we = 1'b0;
  logic        cfg_index = pts_pkg::REG_OFFSETS;
  logic [20:0] cfg_data = '0;

  sieve_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  longint unsigned busy_tail = 0;
  longint unsigned cycles = 0;

  prime_tuple_sieve_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(candidate_index, last_in_word);
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_cmd(logic [1:0] op, logic [31:0] p, logic [31:0] inv,
                          logic [31:0] rem, logic [13:0] w);
    longint res;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    opcode <= op;
    prime <= p;
    inverse <= inv;
    start_residue <= rem;
    word_index <= w;
    do @(posedge clk); while (full);
    res = sb.note_command(op, p, inv, rem, w);
    if (res < -2) busy_tail = 0;
    else if (op == pts_pkg::OP_CLEAR) busy_tail += 17000;
    else if (op == pts_pkg::OP_MARK) busy_tail += 1500 + 4 * res;
    else busy_tail += 100;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (busy_tail + 200) @(posedge clk);
    busy_tail = 0;
  endtask

  task automatic write_cfg(logic idx, logic [20:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pts_pkg::REG_OFFSETS) sb.offsets = val[3:0];
    else sb.max_found = val;
    @(posedge clk);
  endtask

  task automatic random_cmd();
    int sel;
    logic [31:0] p;
    logic [13:0] w;
    sel = $urandom_range(99);
    if (sel < 8) send_cmd(pts_pkg::OP_CLEAR, $urandom, $urandom, $urandom, 14'($urandom));
    else if (sel < 12)
      send_cmd(pts_pkg::OP_UNUSED, $urandom, $urandom, $urandom, 14'($urandom));
    else if (sel < 55) begin
      if ($urandom_range(99) < 25) p = $urandom_range(1 << 20, 4096);
      else p = $urandom;
      if ($urandom_range(99) < 2) p = 0;
      send_cmd(pts_pkg::OP_MARK, p, $urandom,
               ($urandom_range(99) < 85 && p != 0) ? $urandom % p : $urandom,
               14'($urandom));
    end else begin
      w = 14'($urandom);
      if (sb.last_hit >= 0 && $urandom_range(99) < 35) w = 14'(sb.last_hit >> 6);
      send_cmd(pts_pkg::OP_SCAN, $urandom, $urandom, $urandom, w);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (20000) @(posedge clk);

    // directed, reset configuration
    send_cmd(pts_pkg::OP_SCAN, 0, 0, 0, 14'd0);
    send_cmd(pts_pkg::OP_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 14'h3FFF);
    send_cmd(pts_pkg::OP_MARK, 0, 32'h1234, 5, 0);
    send_cmd(pts_pkg::OP_MARK, 1000003, 12345, 5, 0);
    send_cmd(pts_pkg::OP_MARK, 32'hFFFFFFFB, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    send_cmd(pts_pkg::OP_MARK, 65537, 3, 70000, 0);
    send_cmd(pts_pkg::OP_MARK, 4099, 32'hFFFFFFFF, 4000, 0);
    send_cmd(pts_pkg::OP_MARK, 1048583, 7, 32'hFFFFFFFF, 0);
    send_cmd(pts_pkg::OP_SCAN, 0, 0, 0, 14'd0);
    send_cmd(pts_pkg::OP_SCAN, 0, 0, 0, 14'h3FFF);
    send_cmd(pts_pkg::OP_SCAN, 0, 0, 0, 14'(sb.last_hit >> 6));
    send_cmd(pts_pkg::OP_CLEAR, 0, 0, 0, 0);
    send_cmd(pts_pkg::OP_SCAN, 0, 0, 0, 14'd0);
    drain();

    write_cfg(pts_pkg::REG_OFFSETS, 21'd15);
    write_cfg(pts_pkg::REG_MAXCAND, 21'd3);
    send_cmd(pts_pkg::OP_MARK, 2000003, 1, 0, 0);
    send_cmd(pts_pkg::OP_SCAN, 0, 0, 0, 14'd0);
    send_cmd(pts_pkg::OP_SCAN, 0, 0, 0, 14'd1);
    drain();

    write_cfg(pts_pkg::REG_OFFSETS, 21'd0);
    write_cfg(pts_pkg::REG_MAXCAND, 21'd0);
    send_cmd(pts_pkg::OP_CLEAR, 0, 0, 0, 0);
    send_cmd(pts_pkg::OP_MARK, 1048589, 9, 3, 0);
    send_cmd(pts_pkg::OP_SCAN, 0, 0, 0, 14'd5);
    drain();

    write_cfg(pts_pkg::REG_OFFSETS, 21'd1);
    write_cfg(pts_pkg::REG_MAXCAND, 21'h1FFFFF);
    send_cmd(pts_pkg::OP_MARK, 1, $urandom, 0, 0);
    send_cmd(pts_pkg::OP_SCAN, 0, 0, 0, 14'd100);
    send_cmd(pts_pkg::OP_CLEAR, 0, 0, 0, 0);
    send_cmd(pts_pkg::OP_SCAN, 0, 0, 0, 14'd100);
    drain();

    // random streams
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 31 : (ph == 1) ? 46 : 0;
      recv_idle = (ph == 0) ? 46 : (ph == 1) ? 31 : 0;
      write_cfg(pts_pkg::REG_OFFSETS, (ph == 2) ? 21'd14 : 21'($urandom_range(14, 1)));
      write_cfg(pts_pkg::REG_MAXCAND,
                (ph == 1) ? 21'd500 : (ph == 0) ? 21'h1FFFFF : 21'd4096);
      send_cmd(pts_pkg::OP_CLEAR, 0, 0, 0, 0);
      for (int i = 0; i < 80; i++) random_cmd();
      drain();
    end

    if (sb.fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
